// ===== src/fea_pkg.sv =====
// types, constants and arithmetic helpers for the float_exp_approx pipeline
// binary32 multiply / add split into raw, normalise and round steps
// no dependencies
package fea_pkg;

    localparam logic [31:0] INV_LN2 = 32'h3FB8AA3B;
    localparam logic [23:0] LN2_SIG = 24'hB17218;
    localparam logic [31:0] C0      = 32'h3F803884;
    localparam logic [31:0] C1      = 32'h3F72E280;
    localparam logic [31:0] C2      = 32'h3F33AA31;
    localparam logic [30:0] T_LIMIT = 31'h447A0000;
    localparam logic [31:0] POS_INF = 32'h7F800000;
    localparam logic [31:0] QNAN    = 32'h00400000;

    localparam logic [1:0] SP_NONE = 2'd0;
    localparam logic [1:0] SP_INF  = 2'd1;
    localparam logic [1:0] SP_ZERO = 2'd2;
    localparam logic [1:0] SP_NAN  = 2'd3;

    // value = m * 2^(e - 127)
    typedef struct packed {
        logic               s;
        logic signed [11:0] e;
        logic [49:0]        m;
    } t_raw;

    // value = 1.sig * 2^(be - 127), guard and sticky below
    typedef struct packed {
        logic               s;
        logic               z;
        logic signed [11:0] be;
        logic [23:0]        sig;
        logic               g;
        logic               st;
    } t_nrm;

    typedef struct packed {
        logic [31:0]        x;
        logic [31:0]        f;
        logic signed [10:0] k;
        logic [1:0]         sp;
    } t_side;

    function automatic t_raw mul_raw(input logic [31:0] a, input logic [31:0] b);
        logic [7:0]  ea;
        logic [7:0]  eb;
        logic [23:0] ma;
        logic [23:0] mb;
        t_raw        r;
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {a[30:23] != 8'd0, a[22:0]};
        mb = {b[30:23] != 8'd0, b[22:0]};
        r.s = a[31] ^ b[31];
        r.m = {2'b00, 48'(ma) * 48'(mb)};
        r.e = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd173;
        return r;
    endfunction

    function automatic t_raw add_raw(input logic [31:0] a, input logic [31:0] b);
        logic        swap;
        logic [31:0] hi;
        logic [31:0] lo;
        logic [7:0]  eh;
        logic [7:0]  el;
        logic [23:0] mh;
        logic [23:0] ml;
        logic [7:0]  d;
        logic [49:0] bh;
        logic [49:0] bl;
        logic [49:0] bs;
        logic        stb;
        t_raw        r;
        swap = b[30:0] > a[30:0];
        hi   = swap ? b : a;
        lo   = swap ? a : b;
        eh   = (hi[30:23] == 8'd0) ? 8'd1 : hi[30:23];
        el   = (lo[30:23] == 8'd0) ? 8'd1 : lo[30:23];
        mh   = {hi[30:23] != 8'd0, hi[22:0]};
        ml   = {lo[30:23] != 8'd0, lo[22:0]};
        d    = eh - el;
        bh   = {1'b0, mh, 25'b0};
        bl   = {1'b0, ml, 25'b0};
        if (d > 8'd49) begin
            bs  = '0;
            stb = |ml;
        end else begin
            bs  = bl >> d;
            stb = |(bl & ((50'd1 << d) - 50'd1));
        end
        bs[0] = bs[0] | stb;
        r.s = hi[31];
        r.m = (hi[31] == lo[31]) ? bh + bs : bh - bs;
        r.e = $signed({4'b0, eh}) - 12'sd48;
        return r;
    endfunction

    function automatic t_raw kln2_raw(input logic signed [10:0] k);
        logic [10:0] mag;
        t_raw        r;
        mag = k[10] ? 11'(-k) : 11'(k);
        r.s = k[10];
        r.m = 50'(35'(mag) * 35'(LN2_SIG));
        r.e = 12'sd103;
        return r;
    endfunction

    function automatic t_nrm norm(input t_raw raw);
        logic [5:0]  l;
        logic [49:0] sh;
        t_nrm        n;
        l = '0;
        for (int i = 0; i < 50; i++) begin
            if (raw.m[i]) l = 6'(i);
        end
        sh    = raw.m << (6'd49 - l);
        n.s   = raw.s;
        n.z   = (raw.m == '0);
        n.be  = raw.e + $signed({6'b0, l});
        n.sig = sh[49:26];
        n.g   = sh[25];
        n.st  = |sh[24:0];
        return n;
    endfunction

    function automatic logic [31:0] rnd(input t_nrm n);
        logic [24:0]        r;
        logic [49:0]        tmp;
        logic [23:0]        q;
        logic               gg;
        logic               ss;
        logic               inc;
        logic [11:0]        d;
        logic signed [11:0] be2;
        logic [31:0]        o;
        o = '0;
        if (n.z) begin
            o = '0;
        end else if (n.be >= 12'sd1) begin
            inc = n.g & (n.st | n.sig[0]);
            r   = {1'b0, n.sig} + 25'(inc);
            be2 = n.be + (r[24] ? 12'sd1 : 12'sd0);
            if (be2 >= 12'sd255) o = {n.s, POS_INF[30:0]};
            else o = {n.s, be2[7:0], r[24] ? 23'b0 : r[22:0]};
        end else begin
            d = 12'(12'sd1 - n.be);
            if (d > 12'd25) begin
                o = {n.s, 31'b0};
            end else begin
                // subnormal: shift down, keep everything lost in sticky
                tmp = {n.sig, n.g, 25'b0} >> d[4:0];
                q   = tmp[49:26];
                gg  = tmp[25];
                ss  = (|tmp[24:0]) | n.st;
                inc = gg & (ss | q[0]);
                r   = {1'b0, q} + 25'(inc);
                o   = {n.s, 7'b0, r[23], r[22:0]};
            end
        end
        return o;
    endfunction

    function automatic logic signed [10:0] floor_k(input logic [31:0] t);
        logic [23:0] sg;
        logic [4:0]  sa;
        logic [23:0] ip;
        logic        fnz;
        logic [10:0] mag;
        logic signed [10:0] k;
        if (t[30:0] < 31'h3F800000) begin
            k = (t[31] && t[30:0] != '0) ? -11'sd1 : 11'sd0;
        end else begin
            sg  = {1'b1, t[22:0]};
            sa  = 5'(8'd150 - t[30:23]);
            ip  = sg >> sa;
            fnz = |(sg & ((24'd1 << sa) - 24'd1));
            mag = 11'(ip) + 11'(t[31] & fnz);
            k   = t[31] ? -$signed(mag) : $signed(mag);
        end
        return k;
    endfunction

    function automatic logic [31:0] scale(input logic [31:0] p, input t_side sd);
        logic signed [11:0] ne;
        logic [31:0]        o;
        ne = $signed({4'b0, p[30:23]}) + 12'(sd.k);
        case (sd.sp)
            SP_NAN:  o = sd.x | QNAN;
            SP_INF:  o = POS_INF;
            SP_ZERO: o = '0;
            default: begin
                if (p[30:23] == 8'd0 || p[30:23] == 8'hFF) o = p;
                else if (ne >= 12'sd255) o = POS_INF;
                else if (ne <= 12'sd0) o = '0;
                else o = {p[31], ne[7:0], p[22:0]};
            end
        endcase
        return o;
    endfunction

endpackage

// ===== src/float_exp_approx.sv =====
// top level of float_exp_approx: pipelined binary32 approximation of e^x
// depends on fea_pkg for constants and the split float arithmetic
//
// usage:
//   input channel  i_valid / o_stall / i_x_bits carries one binary32 argument
//   output channel o_valid / i_stall / o_exp_bits carries one binary32 result
//   a transfer happens at a rising edge with valid high and stall low
//   one result per argument, in order
// throughput: one transfer per cycle while i_stall is low; the chain of seven
//   float operations (each in multiply/align, normalise and round stages) plus
//   the floor and exponent-scaling stages sets the depth, not the rate
// stall: a stage moves when the next one is empty or moving, so bubbles
//   close up and new arguments are taken while a result waits; o_stall
//   rises only when every stage holds an item
// reset: synchronous, active low, empties the pipeline; no result appears
//   until a new argument is taken
// nan in gives quiet nan out, overflow saturates to +inf, underflow to +0
module float_exp_approx (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_x_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_exp_bits
);
    import fea_pkg::*;

    localparam int NS  = 23;
    localparam int NOP = 7;

    function automatic int a_idx(input int j);
        return (j == 0) ? 0 : 3 * j + 1;
    endfunction

    logic [NS-1:0] r_v;
    logic [NS-1:0] en;
    t_side         r_sd  [NS-1];
    t_side         n_sd  [NS-1];
    t_raw          r_raw [NOP];
    t_raw          n_raw [NOP];
    t_nrm          r_nrm [NOP];
    logic [31:0]   r_fpr [NOP];
    logic [31:0]   r_out;
    t_side         side0;
    logic [31:0]   t_val;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || !i_stall;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !r_v[i] || en[i+1];
        end
    end

    assign o_stall    = !en[0];
    assign o_valid    = r_v[NS-1];
    assign o_exp_bits = r_out;
    assign t_val      = r_fpr[0];

    always_comb begin
        side0.x  = i_x_bits;
        side0.f  = '0;
        side0.k  = '0;
        side0.sp = (i_x_bits[30:23] == 8'hFF && i_x_bits[22:0] != '0) ? SP_NAN : SP_NONE;

        n_sd[0] = side0;
        for (int i = 1; i < NS - 1; i++) begin
            n_sd[i] = r_sd[i-1];
        end
        // floor and range check on t
        n_sd[3].k = floor_k(t_val);
        if (r_sd[2].sp == SP_NONE) begin
            if (!t_val[31] && t_val[30:0] >= T_LIMIT) n_sd[3].sp = SP_INF;
            else if (t_val[31] && t_val[30:0] >= T_LIMIT) n_sd[3].sp = SP_ZERO;
        end
        n_sd[10].f = r_fpr[2];

        n_raw[0] = mul_raw(i_x_bits, INV_LN2);
        n_raw[1] = kln2_raw(r_sd[3].k);
        n_raw[2] = add_raw(r_sd[6].x, {~r_fpr[1][31], r_fpr[1][30:0]});
        n_raw[3] = mul_raw(r_fpr[2], C2);
        n_raw[4] = add_raw(r_fpr[3], C1);
        n_raw[5] = mul_raw(r_sd[15].f, r_fpr[4]);
        n_raw[6] = add_raw(r_fpr[5], C0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int i = 1; i < NS; i++) begin
                if (en[i]) r_v[i] <= r_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NS - 1; i++) begin
            if (en[i]) r_sd[i] <= n_sd[i];
        end
        for (int j = 0; j < NOP; j++) begin
            if (en[a_idx(j)])     r_raw[j] <= n_raw[j];
            if (en[a_idx(j) + 1]) r_nrm[j] <= norm(r_raw[j]);
            if (en[a_idx(j) + 2]) r_fpr[j] <= rnd(r_nrm[j]);
        end
        if (en[NS-1]) r_out <= scale(r_fpr[6], r_sd[NS-2]);
    end

endmodule
